[rtl/core/dldr_pkg.sv]
// ---------------------------------------------------------------------------
// dldr_pkg: shared types and codes for the deadlock detect and recover block
// Holds request codes, result kinds, configuration register indexes and the
// counter saturation limit.
// ---------------------------------------------------------------------------
`default_nettype none
package dldr_pkg;
    localparam int CNT_W = 12;
    localparam int VAL_W = 8;
    localparam logic [CNT_W-1:0] COUNT_MAX = 12'hfff;

    typedef logic [1:0] t_req;
    localparam t_req REQ_AVAIL = 2'd0;
    localparam t_req REQ_HELD  = 2'd1;
    localparam t_req REQ_WANT  = 2'd2;
    localparam t_req REQ_RUN   = 2'd3;

    localparam logic KIND_VICTIM = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_POLICY  = 2'd0;
    localparam t_cfg_idx CFG_THREADS = 2'd1;
    localparam t_cfg_idx CFG_RES     = 2'd2;
endpackage
`default_nettype wire

[rtl/core/deadlock_detect_and_recover.sv]
// Steps: a load gives no result. A run repeats, per round (one per victim, plus a final one),
// an empty-row sweep over THREADS*RESOURCES cells, up to THREADS+1 fit scans with an add of
// RESOURCES cells per finished row, a victim sum scan, a release of the victim row and a wait
// for the result to drain.
// Throughput: one transaction at a time; o_stall stays high for the whole run.
// Reset: synchronous active low; counts and matrices clear, policy 1, 8 threads, 4 res.
// ---------------------------------------------------------------------------
// deadlock_detect_and_recover: multi-instance deadlock detection and recovery
// Sequencer walks the matrices cell by cell through one shared cell read and saturating add.
// ---------------------------------------------------------------------------
`default_nettype none
module deadlock_detect_and_recover #(
    parameter int THREADS   = 8,
    parameter int RESOURCES = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire dldr_pkg::t_req         i_req_type,
    input  wire logic [2:0]             i_thread_sel,
    input  wire logic [1:0]             i_resource_sel,
    input  wire logic [7:0]             i_value,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire dldr_pkg::t_cfg_idx     i_cfg_index,
    input  wire logic [3:0]             i_cfg_data,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic                        o_kind,
    output logic [2:0]                  o_victim,
    output logic [7:0]                  o_deadlocked_set,
    output logic                        o_last
);
    import dldr_pkg::*;

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int SW = VAL_W + RW + 1;
    localparam int CELLS = THREADS * RESOURCES;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EMPTY = 3'd1;   // find threads holding nothing
    localparam logic [2:0] S_SCAN  = 3'd2;   // test request fits in work
    localparam logic [2:0] S_ADD   = 3'd3;   // add allocation into work
    localparam logic [2:0] S_SUM   = 3'd4;   // victim sum scan
    localparam logic [2:0] S_REL   = 3'd5;   // release victim row
    localparam logic [2:0] S_OUT   = 3'd6;   // wait for result to drain

    logic [2:0]        r_state;
    logic              r_policy;
    logic [3:0]        r_nthr;
    logic [2:0]        r_nres;
    logic [CNT_W-1:0]  r_avail [RESOURCES];
    logic [CNT_W-1:0]  r_work  [RESOURCES];
    logic [VAL_W-1:0]  r_held  [CELLS];
    logic [VAL_W-1:0]  r_want  [CELLS];
    logic [THREADS-1:0] r_fin;
    logic [TW-1:0]     r_t;
    logic [RW-1:0]     r_r;
    logic              r_ok;
    logic [SW-1:0]     r_sum, r_best;
    logic              r_have;
    logic [TW-1:0]     r_pick;
    logic              r_done_run;
    logic              r_ov;
    logic              r_okind, r_olast;
    logic [2:0]        r_ovict;
    logic [7:0]        r_odead;

    // effective counts, clamped
    logic [5:0] w_nt;
    logic [4:0] w_nr;
    always_comb begin
        w_nt = (32'(r_nthr) > THREADS) ? 6'(THREADS) : 6'(r_nthr);
        w_nr = (32'(r_nres) > RESOURCES) ? 5'(RESOURCES) : 5'(r_nres);
    end

    logic [THREADS-1:0] w_active, w_dead;
    always_comb begin
        for (int k = 0; k < THREADS; k++) w_active[k] = (k < 32'(w_nt));
        w_dead = w_active & ~r_fin;
    end

    // shared unit: one cell address and one saturating add
    logic [TW+RW-1:0] w_cell;
    logic [TW-1:0]    w_trow;
    logic [VAL_W-1:0] w_h, w_w;
    logic [CNT_W:0]   w_add;
    logic [CNT_W-1:0] w_addsat, w_opnd;
    logic             w_last_r, w_last_t;
    always_comb begin
        w_trow   = (r_state == S_REL) ? r_pick : r_t;
        w_cell   = TW'(w_trow) * (TW+RW)'(RESOURCES) + (TW+RW)'(r_r);
        w_h      = r_held[w_cell];
        w_w      = r_want[w_cell];
        w_opnd   = (r_state == S_REL) ? r_avail[r_r] : r_work[r_r];
        w_add    = {1'b0, w_opnd} + (CNT_W+1)'(w_h);
        w_addsat = w_add[CNT_W] ? COUNT_MAX : w_add[CNT_W-1:0];
        w_last_r = (32'(r_r) + 1 >= 32'(w_nr));
        w_last_t = (32'(r_t) + 1 >= 32'(w_nt));
    end

    logic [SW-1:0] w_sumn;
    logic          w_better;
    always_comb begin
        w_sumn   = r_sum + SW'(w_h);
        w_better = !r_have || (r_policy ? (w_sumn >= r_best) : (w_sumn <= r_best));
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_ov;
    assign o_kind      = r_okind;
    assign o_victim    = r_ovict;
    assign o_deadlocked_set = r_odead;
    assign o_last      = r_olast;

    logic w_acc;
    assign w_acc = i_valid && !o_stall;

    // cell addressed by a load
    logic [TW+RW-1:0] w_ld_cell;
    assign w_ld_cell = (TW+RW)'(i_thread_sel) * (TW+RW)'(RESOURCES)
                     + (TW+RW)'(i_resource_sel);

    // matrix storage, written by loads and by the release sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CELLS; k++) begin
                r_held[k] <= '0;
                r_want[k] <= '0;
            end
        end else if (w_acc && (i_req_type == REQ_HELD || i_req_type == REQ_WANT)) begin
            if (32'(i_thread_sel) < THREADS && 32'(i_resource_sel) < RESOURCES) begin
                if (i_req_type == REQ_HELD)
                    r_held[w_ld_cell] <= i_value;
                else
                    r_want[w_ld_cell] <= i_value;
            end
        end else if (r_state == S_REL && 32'(w_nr) != 0) begin
            r_held[w_cell] <= '0;
            r_want[w_cell] <= '0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= 1'b1;
            r_nthr   <= 4'd8;
            r_nres   <= 3'd4;
            r_fin    <= '0;
            r_ov     <= 1'b0;
            for (int k = 0; k < RESOURCES; k++) begin
                r_avail[k] <= '0;
                r_work[k]  <= '0;
            end
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_POLICY:  r_policy <= i_cfg_data[0];
                    CFG_THREADS: r_nthr   <= i_cfg_data;
                    CFG_RES:     r_nres   <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (i_req_type)
                            REQ_AVAIL: if (32'(i_resource_sel) < RESOURCES)
                                r_avail[i_resource_sel[RW-1:0]] <= CNT_W'(i_value);
                            REQ_RUN: begin
                                for (int k = 0; k < RESOURCES; k++) r_work[k] <= r_avail[k];
                                r_fin <= '0;
                                r_t <= '0; r_r <= '0; r_ok <= 1'b1;
                                r_state <= S_EMPTY;
                            end
                            default: ;
                        endcase
                    end
                end
                S_EMPTY: begin
                    // r_ok tracks "row empty"; skip when no threads
                    if (w_nt == 0) begin
                        r_t <= '0; r_r <= '0; r_ok <= 1'b1; r_state <= S_SCAN;
                    end else begin
                        logic e;
                        e = r_ok && (w_nr == 0 || w_h == 0);
                        if (w_nr == 0 || w_last_r) begin
                            if (e) r_fin[r_t] <= 1'b1;
                            r_r <= '0; r_ok <= 1'b1;
                            if (w_last_t) begin
                                r_t <= '0; r_state <= S_SCAN;
                            end else r_t <= r_t + 1'b1;
                        end else begin
                            r_ok <= e; r_r <= r_r + 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_nt == 0 || r_fin[r_t]) begin
                        r_r <= '0; r_ok <= 1'b1;
                        if (w_nt == 0 || w_last_t) begin
                            r_t <= '0; r_sum <= '0; r_have <= 1'b0; r_state <= S_SUM;
                        end else r_t <= r_t + 1'b1;
                    end else begin
                        logic f;
                        f = r_ok && (w_nr == 0 || CNT_W'(w_w) <= r_work[r_r]);
                        if (w_nr == 0 || w_last_r) begin
                            r_r <= '0; r_ok <= 1'b1;
                            if (f) begin
                                r_fin[r_t] <= 1'b1;
                                if (w_nr == 0) r_t <= '0;
                                else r_state <= S_ADD;
                            end else if (w_last_t) begin
                                r_t <= '0; r_sum <= '0; r_have <= 1'b0; r_state <= S_SUM;
                            end else r_t <= r_t + 1'b1;
                        end else begin
                            r_ok <= f; r_r <= r_r + 1'b1;
                        end
                    end
                end
                S_ADD: begin
                    r_work[r_r] <= w_addsat;
                    if (w_last_r) begin
                        r_r <= '0; r_t <= '0; r_state <= S_SCAN;
                    end else r_r <= r_r + 1'b1;
                end
                S_SUM: begin
                    if (w_dead == '0) begin
                        r_okind <= KIND_DONE; r_ovict <= '0; r_odead <= '0;
                        r_olast <= 1'b1; r_ov <= 1'b1; r_done_run <= 1'b1;
                        r_state <= S_OUT;
                    end else if (!w_dead[r_t]) begin
                        // skip a live thread; the last active thread ends the scan
                        if (w_last_t) r_state <= S_REL;
                        else r_t <= r_t + 1'b1;
                    end else if (w_nr == 0 || w_last_r) begin
                        if (w_better) begin
                            r_best <= (w_nr == 0) ? '0 : w_sumn;
                            r_pick <= r_t; r_have <= 1'b1;
                        end
                        r_sum <= '0; r_r <= '0;
                        if (w_last_t) r_state <= S_REL;
                        else r_t <= r_t + 1'b1;
                    end else begin
                        r_sum <= w_sumn; r_r <= r_r + 1'b1;
                    end
                end
                S_REL: begin
                    if (w_nr != 0) r_avail[r_r] <= w_addsat;
                    if (w_nr == 0 || w_last_r) begin
                        r_okind <= KIND_VICTIM; r_ovict <= 3'(r_pick);
                        r_odead <= 8'(w_dead); r_olast <= 1'b0;
                        r_ov <= 1'b1; r_done_run <= 1'b0;
                        r_state <= S_OUT;
                    end
                    r_r <= (w_nr == 0 || w_last_r) ? '0 : r_r + 1'b1;
                end
                S_OUT: begin
                    if (!r_ov || !i_stall) begin
                        if (r_done_run) r_state <= S_IDLE;
                        else begin
                            for (int k = 0; k < RESOURCES; k++) r_work[k] <= r_avail[k];
                            r_fin <= '0; r_t <= '0; r_r <= '0; r_ok <= 1'b1;
                            r_state <= S_EMPTY;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/dldr_checker.sv]
// ---------------------------------------------------------------------------
// dldr_checker: port-level checks for deadlock_detect_and_recover
// Watches the result stream of runs and the idle handshake.
// ---------------------------------------------------------------------------
`default_nettype none
module dldr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_cfg_ready,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_kind,
    input wire logic [2:0] o_victim,
    input wire logic [7:0] o_deadlocked_set,
    input wire logic       o_last
);
    // a done result is the last of its run and carries nothing else
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_last && o_victim == 3'd0 && o_deadlocked_set == 8'd0)
        else $error("done result malformed");
    // a victim result names a thread inside its deadlocked set
    a_victim_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> !o_last && o_deadlocked_set[o_victim])
        else $error("victim not in deadlocked set");
    // configuration port opens only while the input side is idle
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready == !o_stall)
        else $error("config ready while busy");
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_victim))
        else $error("result dropped under stall");
endmodule

bind deadlock_detect_and_recover dldr_checker u_dldr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall), .o_cfg_ready(o_cfg_ready),
    .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind), .o_victim(o_victim),
    .o_deadlocked_set(o_deadlocked_set), .o_last(o_last)
);
`default_nettype wire

[test/tb_deadlock_detect_and_recover.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_deadlock_detect_and_recover: self-checking bench for deadlock recovery
// Loads random and hand-built allocation/request matrices, runs detection
// under several register settings and idle patterns, and checks every result
// transaction against an in-bench model of the detect/victim/release loop.
// ---------------------------------------------------------------------------
`default_nettype none

class dldr_scoreboard;
    bit        policy_largest;
    int        thread_cnt;
    int        res_cnt;
    bit [11:0] avail [4];
    bit [7:0]  held [8][4];
    bit [7:0]  wanted [8][4];
    bit [12:0] exp_q [$];
    int        errors;
    int        results_seen;
    int        victims_seen;

    function new();
        reset_state();
    endfunction

    function void reset_state();
        policy_largest = 1;
        thread_cnt = 8;
        res_cnt = 4;
        foreach (avail[r]) avail[r] = '0;
        foreach (held[t, r]) begin
            held[t][r] = '0;
            wanted[t][r] = '0;
        end
    endfunction

    function void write_reg(dldr_pkg::t_cfg_idx idx, bit [3:0] data);
        case (idx)
            dldr_pkg::CFG_POLICY:  policy_largest = data[0];
            dldr_pkg::CFG_THREADS: thread_cnt = (data > 8) ? 8 : data;
            dldr_pkg::CFG_RES:     res_cnt = (data[2:0] > 4) ? 4 : data[2:0];
            default: ;
        endcase
    endfunction

    function bit [11:0] sat_sum(bit [11:0] a, bit [7:0] b);
        bit [12:0] s;
        s = a + b;
        return (s > 13'd4095) ? 12'hfff : s[11:0];
    endfunction

    // Return the mask of active threads that cannot finish.
    function bit [7:0] find_stuck();
        bit [11:0] work [4];
        bit [7:0]  done;
        bit        moved;
        bit        fits;
        bit [7:0]  stuck;
        done = '0;
        stuck = '0;
        foreach (work[r]) work[r] = avail[r];
        for (int t = 0; t < thread_cnt; t++) begin
            fits = 1;
            for (int r = 0; r < res_cnt; r++) if (held[t][r] != 0) fits = 0;
            if (fits) done[t] = 1;
        end
        moved = 1;
        while (moved) begin
            moved = 0;
            for (int t = 0; t < thread_cnt && !moved; t++) begin
                if (!done[t]) begin
                    fits = 1;
                    for (int r = 0; r < res_cnt; r++)
                        if (wanted[t][r] > work[r]) fits = 0;
                    if (fits) begin
                        for (int r = 0; r < res_cnt; r++)
                            work[r] = sat_sum(work[r], held[t][r]);
                        done[t] = 1;
                        moved = 1;
                    end
                end
            end
        end
        for (int t = 0; t < thread_cnt; t++) if (!done[t]) stuck[t] = 1;
        return stuck;
    endfunction

    // Note an accepted input transaction and queue the results it causes.
    function void note_input(dldr_pkg::t_req kind, bit [2:0] ts, bit [1:0] rs,
                             bit [7:0] val);
        bit [7:0] stuck;
        int       pick;
        int       best;
        int       sum;
        bit       have;
        case (kind)
            dldr_pkg::REQ_AVAIL: avail[rs] = val;
            dldr_pkg::REQ_HELD:  held[ts][rs] = val;
            dldr_pkg::REQ_WANT:  wanted[ts][rs] = val;
            default: begin
                stuck = find_stuck();
                while (stuck != 0) begin
                    have = 0;
                    pick = 0;
                    best = 0;
                    for (int t = 0; t < thread_cnt; t++) begin
                        if (stuck[t]) begin
                            sum = 0;
                            for (int r = 0; r < res_cnt; r++) sum += held[t][r];
                            if (!have || (policy_largest ? sum >= best : sum <= best)) begin
                                best = sum;
                                pick = t;
                                have = 1;
                            end
                        end
                    end
                    for (int r = 0; r < res_cnt; r++) begin
                        avail[r] = sat_sum(avail[r], held[pick][r]);
                        held[pick][r] = '0;
                        wanted[pick][r] = '0;
                    end
                    exp_q.push_back({dldr_pkg::KIND_VICTIM, 3'(pick), stuck, 1'b0});
                    stuck = find_stuck();
                end
                exp_q.push_back({dldr_pkg::KIND_DONE, 3'd0, 8'd0, 1'b1});
            end
        endcase
    endfunction

    // Compare one result transaction with the oldest expectation.
    function void check_result(bit kind, bit [2:0] victim, bit [7:0] dset, bit last);
        bit [12:0] e;
        results_seen++;
        if (exp_q.size() == 0) begin
            $error("unexpected result kind=%0d victim=%0d set=%h", kind, victim, dset);
            errors++;
            return;
        end
        e = exp_q.pop_front();
        if (kind == dldr_pkg::KIND_VICTIM) victims_seen++;
        if (e[12] !== kind) begin
            $error("kind: expected %0d, got %0d", e[12], kind);
            errors++;
        end
        if (e[11:9] !== victim) begin
            $error("victim: expected %0d, got %0d", e[11:9], victim);
            errors++;
        end
        if (e[8:1] !== dset) begin
            $error("deadlocked_set: expected %h, got %h", e[8:1], dset);
            errors++;
        end
        if (e[0] !== last) begin
            $error("last: expected %0d, got %0d", e[0], last);
            errors++;
        end
    endfunction
endclass

module tb_deadlock_detect_and_recover;
    import dldr_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_valid = 0;
    logic       o_stall;
    t_req       i_req_type = REQ_AVAIL;
    logic [2:0] i_thread_sel = '0;
    logic [1:0] i_resource_sel = '0;
    logic [7:0] i_value = '0;
    logic       i_cfg_valid = 0;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index = CFG_POLICY;
    logic [3:0] i_cfg_data = '0;
    logic       o_valid;
    logic       i_stall = 0;
    logic       o_kind;
    logic [2:0] o_victim;
    logic [7:0] o_deadlocked_set;
    logic       o_last;

    dldr_scoreboard sb = new();
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 0;
    int  runs_sent = 0;

    always #5 i_clk = ~i_clk;

    deadlock_detect_and_recover i_dut (.*);

    // Count cycles and stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Drive receiver stall and check each result transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_kind, o_victim, o_deadlocked_set, o_last);
        i_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // Offer one transaction and hold it until accepted; valid stays up for the next one.
    task automatic send_item(t_req kind, bit [2:0] ts, bit [1:0] rs, bit [7:0] val);
        i_cfg_valid <= 0;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1;
        i_req_type <= kind;
        i_thread_sel <= ts;
        i_resource_sel <= rs;
        i_value <= val;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(kind, ts, rs, val);
        if (kind == REQ_RUN) runs_sent++;
    endtask

    // Drop both senders and wait until every expected result is in.
    task automatic drain();
        i_valid <= 0;
        i_cfg_valid <= 0;
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [3:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Build a random matrix set; small values make deadlocks likely.
    task automatic load_scenario(bit wide);
        for (int r = 0; r < 4; r++)
            send_item(REQ_AVAIL, 3'($urandom), 2'(r),
                      wide ? 8'($urandom) : 8'($urandom_range(3)));
        for (int t = 0; t < 8; t++)
            for (int r = 0; r < 4; r++) begin
                if ($urandom_range(15) < 7)
                    send_item(REQ_HELD, 3'(t), 2'(r),
                              wide ? 8'($urandom) : 8'($urandom_range(3)));
                if ($urandom_range(15) < 7)
                    send_item(REQ_WANT, 3'(t), 2'(r),
                              wide ? 8'($urandom) : 8'($urandom_range(4)));
            end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: circular wait at reset settings, extremes, saturation.
        send_item(REQ_RUN, 3'd0, 2'd0, 8'd0);
        send_item(REQ_HELD, 3'd0, 2'd0, 8'd255);
        send_item(REQ_WANT, 3'd0, 2'd1, 8'd1);
        send_item(REQ_HELD, 3'd7, 2'd1, 8'd255);
        send_item(REQ_WANT, 3'd7, 2'd0, 8'd1);
        send_item(REQ_HELD, 3'd3, 2'd3, 8'd1);
        send_item(REQ_WANT, 3'd3, 2'd3, 8'd255);
        send_item(REQ_AVAIL, 3'd7, 2'd3, 8'd255);
        send_item(REQ_RUN, 3'd7, 2'd3, 8'd255);
        for (int r = 0; r < 4; r++) send_item(REQ_AVAIL, 3'd0, 2'(r), 8'd255);
        for (int t = 0; t < 8; t++) send_item(REQ_HELD, 3'(t), 2'd2, 8'd255);
        send_item(REQ_RUN, 3'd5, 2'd1, 8'd17);
        drain();

        // Walk register settings including extremes and out-of-range values.
        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            write_reg(CFG_POLICY, 4'($urandom_range(1)));
            write_reg(CFG_THREADS, (phase == 0) ? 4'd15 : (phase == 1) ? 4'd1 :
                      (phase == 2) ? 4'd0 : 4'($urandom_range(1, 8)));
            write_reg(CFG_RES, (phase == 3) ? 4'd7 : (phase == 4) ? 4'd1 :
                      (phase == 5) ? 4'd0 : 4'($urandom_range(1, 4)));
            if ($urandom_range(4) == 0) load_scenario(1);
            else load_scenario(0);
            send_item(REQ_RUN, 3'($urandom), 2'($urandom), 8'($urandom));
            if (phase == 6) begin
                // Long receiver hold-off while loads and runs keep coming.
                hold_off = 1;
                fork
                    begin repeat (600) @(posedge i_clk); hold_off = 0; end
                    begin
                        for (int k = 0; k < 4; k++) begin
                            send_item(REQ_HELD, 3'($urandom), 2'($urandom), 8'd1);
                            send_item(REQ_WANT, 3'($urandom), 2'($urandom), 8'd9);
                            send_item(REQ_RUN, 3'd0, 2'd0, 8'd0);
                        end
                    end
                join
            end
            drain();
        end

        write_reg(CFG_POLICY, 4'd1);
        write_reg(CFG_THREADS, 4'd8);
        write_reg(CFG_RES, 4'd4);
        drain();
        $display("Covered %0d runs, %0d results, %0d victims across 12 settings.",
                 runs_sent, sb.results_seen, sb.victims_seen);
        if (sb.errors == 0 && sb.exp_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire

[files.f]
rtl/core/dldr_pkg.sv
rtl/core/deadlock_detect_and_recover.sv
rtl/core/dldr_checker.sv
test/tb_deadlock_detect_and_recover.sv
